FILE: rtl/sle_pkg.sv
// Shared types and codes for the sorted list engine.
package sle_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_READOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } sle_cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } sle_status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } sle_req_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic               last;
  } sle_rsp_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic ins;  // open a slot at the insert point, shift upper cells up
    logic del;  // close the slot at the match point, shift upper cells down
    logic rot;  // rotate the whole ring down by one cell
  } sle_ctrl_t;

endpackage

FILE: rtl/sle_cell.sv
// One storage cell of the sorted list chain.
module sle_cell (
  input  logic               clk,
  input  sle_pkg::sle_ctrl_t ctrl,
  input  logic signed [31:0] key,
  input  logic               valid,
  input  logic signed [31:0] left_val,
  input  logic               left_less,
  input  logic signed [31:0] right_val,
  output logic signed [31:0] val,
  output logic               less,
  output logic               found
);
  import sle_pkg::*;

  assign less  = valid && (val < key);
  // First equal entry: the cell just past the run of smaller entries.
  assign found = valid && (val == key) && !less && left_less;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!less) begin
        val <= left_less ? key : left_val;
      end
    end else if (ctrl.del) begin
      if (!less) begin
        val <= right_val;
      end
    end else if (ctrl.rot) begin
      val <= right_val;
    end
  end

endmodule

FILE: rtl/sorted_list_engine.sv
// Sorted list engine: a ring of compare-and-shift cells with a command sequencer.
// Insert and delete: the result is registered in the cycle after acceptance.
// Readout of n entries: the ring rotates DEPTH times, emitting the first n as results;
//   it holds off the request channel until all DEPTH rotations are done, through any result-channel stalls.
// A waiting result holds off the request channel; the next request enters on the edge it is taken.
// Reset (rst, synchronous, active high) empties the list and drops any pending result.
module sorted_list_engine #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sle_pkg::sle_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sle_pkg::sle_rsp_t rsp
);
  import sle_pkg::*;

  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    IDLE,
    READ
  } state_t;

  state_t             state;
  logic [OW-1:0]      occ;
  logic [CW-1:0]      cnt;

  sle_ctrl_t          ctrl;
  logic signed [31:0] cell_val [DEPTH];
  logic [DEPTH-1:0]   cell_less;
  logic [DEPTH-1:0]   cell_found;

  logic accept;
  logic out_free;
  logic full;
  logic found;
  logic rd_pending;
  logic emit;
  logic rsp_load;

  // The output register is free when empty or being drained this cycle.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state == READ) || !out_free;
  assign accept    = req_valid && !req_stall;

  assign full  = (occ == OW'(DEPTH));
  assign found = |cell_found;

  // During readout, entries still to be sent wait for the output register;
  // the unused tail of the ring rotates freely to restore the order.
  assign rd_pending = ({{(OW > CW ? OW - CW : 0){1'b0}}, cnt} < occ);
  assign emit       = (state == READ) && rd_pending && out_free;

  // Load the output register for every insert or delete, an empty readout,
  // and each entry sent during readout.
  assign rsp_load = emit ||
                    (accept && ((req.cmd == CMD_INSERT) || (req.cmd == CMD_DELETE) ||
                                ((req.cmd == CMD_READOUT) && (occ == '0))));

  assign ctrl.ins = accept && (req.cmd == CMD_INSERT) && !full;
  assign ctrl.del = accept && (req.cmd == CMD_DELETE) && found;
  assign ctrl.rot = (state == READ) && (rd_pending ? out_free : 1'b1);

  // Ring of cells: each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LEFT  = (i + DEPTH - 1) % DEPTH;
    localparam int RIGHT = (i + 1) % DEPTH;

    logic valid_i;
    logic left_less_i;

    assign valid_i     = (occ > OW'(i));
    assign left_less_i = (i == 0) ? 1'b1 : cell_less[LEFT];

    sle_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (req.value),
      .valid     (valid_i),
      .left_val  (cell_val[LEFT]),
      .left_less (left_less_i),
      .right_val (cell_val[RIGHT]),
      .val       (cell_val[i]),
      .less      (cell_less[i]),
      .found     (cell_found[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      occ       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise valid for a new result; drop the held one once it is taken.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (out_free) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            unique case (req.cmd)
              CMD_INSERT: begin
                rsp.item    <= req.value;
                rsp.status  <= full ? ST_FULL : ST_OK;
                rsp.last    <= 1'b1;
                if (!full) begin
                  occ <= occ + 1'b1;
                end
              end
              CMD_DELETE: begin
                rsp.item    <= req.value;
                rsp.last    <= 1'b1;
                if (occ == '0) begin
                  rsp.status <= ST_EMPTY;
                end else if (found) begin
                  rsp.status <= ST_OK;
                  occ        <= occ - 1'b1;
                end else begin
                  rsp.status <= ST_NOTFOUND;
                end
              end
              CMD_READOUT: begin
                if (occ == '0) begin
                  rsp.item   <= '0;
                  rsp.status <= ST_EMPTY;
                  rsp.last   <= 1'b1;
                end else begin
                  state <= READ;
                  cnt   <= '0;
                end
              end
              default: begin
                // Unused code: accept and ignore.
              end
            endcase
          end
        end
        READ: begin
          if (emit) begin
            rsp.item   <= cell_val[0];
            rsp.status <= ST_OK;
            rsp.last   <= ({{(OW > CW ? OW - CW : 0){1'b0}}, cnt} == occ - 1'b1);
          end
          if (ctrl.rot) begin
            cnt <= cnt + 1'b1;
            if (cnt == CW'(DEPTH - 1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sle_checker.sv
// Port-level checks for the sorted list engine and their bind.
module sle_assertions (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input sle_pkg::sle_req_t req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input sle_pkg::sle_rsp_t rsp
);
  import sle_pkg::*;

  logic acc_upd;
  logic acc_ins;

  assign acc_upd = req_valid && !req_stall &&
                   ((req.cmd == CMD_INSERT) || (req.cmd == CMD_DELETE));
  assign acc_ins = req_valid && !req_stall && (req.cmd == CMD_INSERT);

  // Hold a stalled result.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Insert and delete answer in the next cycle with the handled value.
  a_upd_answer: assert property (@(posedge clk) disable iff (rst)
    acc_upd |=> rsp_valid && rsp.last && (rsp.item == $past(req.value)))
    else $error("insert/delete result missing or wrong");

  // An insert reports only ok or full.
  a_ins_status: assert property (@(posedge clk) disable iff (rst)
    acc_ins |=> (rsp.status == ST_OK) || (rsp.status == ST_FULL))
    else $error("insert reported a bad status");

  // Only readout produces non-final results, and those are ok.
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_OK)
    else $error("non-final result without ok status");

endmodule

bind sorted_list_engine sle_assertions u_sle_assertions (.*);
